// ===== rtl/bba_pkg.sv =====
// Shared constants, types and helper functions for the block pool allocator.
`timescale 1ns / 1ps
package bba_pkg;

  localparam int unsigned MAX_BLOCKS  = 32;
  localparam int unsigned IDX_W       = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned BSIZE_W     = 24;
  localparam int unsigned ALIGN_BYTES = 4;
  // aligned size can reach 2^24, so one bit more than the register
  localparam int unsigned SIZE_W      = BSIZE_W + 1;

  // response status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_BSIZE = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } op_e;

  // count clipped to the pool capacity
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] n);
    if (n > CNT_W'(MAX_BLOCKS)) begin
      return CNT_W'(MAX_BLOCKS);
    end
    return n;
  endfunction

  // one set bit for each configured block
  function automatic logic [MAX_BLOCKS-1:0] init_map(input logic [CNT_W-1:0] n);
    logic [MAX_BLOCKS-1:0] m;
    logic [CNT_W-1:0]      e;
    e = eff_count(n);
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      m[i] = (CNT_W'(i) < e);
    end
    return m;
  endfunction

  // block size rounded up to the alignment
  function automatic logic [SIZE_W-1:0] align_size(input logic [BSIZE_W-1:0] v);
    logic [SIZE_W-1:0] s;
    s = {1'b0, v} + SIZE_W'(ALIGN_BYTES - 1);
    return s & ~SIZE_W'(ALIGN_BYTES - 1);
  endfunction

endpackage

// ===== rtl/bba_if.sv =====
// Request and response channel interfaces of the block pool allocator.
`timescale 1ns / 1ps
interface bba_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] address;

  modport source (output valid, kind, address, input ready);
  modport sink   (input valid, kind, address, output ready);
endinterface

interface bba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] block_address;
  logic [5:0]  in_use_count;
  logic [5:0]  peak_count;
  logic [31:0] failure_count;

  modport source (output valid, status, block_address, in_use_count, peak_count,
                  failure_count, input ready);
  modport sink   (input valid, status, block_address, in_use_count, peak_count,
                  failure_count, output ready);
endinterface

// ===== rtl/bba_find_first.sv =====
// Lowest set bit finder over the free bitmap.
`timescale 1ns / 1ps
module bba_find_first (
  input  logic [bba_pkg::MAX_BLOCKS-1:0] map_i,
  output logic [bba_pkg::IDX_W-1:0]      idx_o
);
  import bba_pkg::*;

  always_comb begin
    idx_o = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (map_i[i]) begin
        idx_o = IDX_W'(i);
      end
    end
  end

endmodule

// ===== rtl/bba_serial_unit.sv =====
// Shared shift/add unit: restoring divide and shift-add multiply on one adder.
`timescale 1ns / 1ps
module bba_serial_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  bba_pkg::op_e                op_i,
  input  logic [bba_pkg::ADDR_W-1:0]  opa_i,    // addend (mul) or dividend (div)
  input  logic [bba_pkg::SIZE_W-1:0]  opb_i,    // multiplicand or divisor
  input  logic [bba_pkg::IDX_W-1:0]   mplier_i,
  output logic                        done_o,
  output logic [bba_pkg::ADDR_W-1:0]  res_o,    // sum or quotient
  output logic [bba_pkg::SIZE_W-1:0]  rem_o
);
  import bba_pkg::*;

  localparam int unsigned STEP_W = $clog2(ADDR_W);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  op_e                 op_q, op_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic [ADDR_W-1:0]   acc_q, acc_d;
  logic [ADDR_W-1:0]   mcand_q, mcand_d;
  logic [SIZE_W-1:0]   rem_q, rem_d;
  logic [IDX_W-1:0]    mplier_q, mplier_d;

  logic [SIZE_W:0]     trial;
  logic [ADDR_W-1:0]   add_a, add_b;
  logic                add_cin;
  logic [ADDR_W:0]     sum;

  assign trial = {rem_q, acc_q[ADDR_W-1]};

  // the one adder; divide uses it as a subtract with carry-out as no-borrow
  always_comb begin
    if (op_q == OP_DIV) begin
      add_a   = ADDR_W'(trial);
      add_b   = ~mcand_q;
      add_cin = 1'b1;
    end else begin
      add_a   = acc_q;
      add_b   = mcand_q;
      add_cin = 1'b0;
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {{ADDR_W{1'b0}}, add_cin};
  end

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    op_d     = op_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    rem_d    = rem_q;
    mplier_d = mplier_q;
    if (start_i) begin
      busy_d   = 1'b1;
      op_d     = op_i;
      acc_d    = opa_i;
      mcand_d  = ADDR_W'(opb_i);
      rem_d    = '0;
      mplier_d = mplier_i;
      cnt_d    = (op_i == OP_DIV) ? STEP_W'(ADDR_W - 1) : STEP_W'(IDX_W - 1);
    end else if (busy_q) begin
      if (op_q == OP_DIV) begin
        if (sum[ADDR_W]) begin
          rem_d = sum[SIZE_W-1:0];
        end else begin
          rem_d = trial[SIZE_W-1:0];
        end
        acc_d = {acc_q[ADDR_W-2:0], sum[ADDR_W]};
      end else begin
        if (mplier_q[0]) begin
          acc_d = sum[ADDR_W-1:0];
        end
        mcand_d  = {mcand_q[ADDR_W-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[IDX_W-1:1]};
      end
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    rem_q    <= rem_d;
    mplier_q <= mplier_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/bitmap_block_allocator.sv =====
// Top level of the fixed-size block pool allocator with a free bitmap.
//
// Requests arrive on the req channel (kind: allocate or free, address of the
// block to free); one response per request leaves on the rsp channel with the
// status, allocated address and the in-use, peak and failed-allocate counters.
// Configuration (base address, block size, block count) is written through
// cfg_we_i / cfg_index_i / cfg_data_i while no request is in flight; a write
// to any of these three registers reinitialises the bitmap and all counters.
// A request is taken only when the block is idle. A free runs a 32-step
// restoring divide of (address - base) by the aligned block size on the shared
// shift/add unit; an allocate uses the same unit for a 5-step shift-add
// index * size. The next request is accepted in the cycle after the response
// is loaded. The response sits in an output register; if the receiver
// stalls, the next request is still taken and processed, and its result
// waits until the register frees up.
// Reset gives base 0, block size 4, 32 blocks, all blocks free, counters zero.
`timescale 1ns / 1ps
module bitmap_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  bba_req_if.sink     req,
  bba_rsp_if.source   rsp
);
  import bba_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [ADDR_W-1:0]     base_q;
  logic [BSIZE_W-1:0]    bsize_q;
  logic [CNT_W-1:0]      bcount_q;
  logic [MAX_BLOCKS-1:0] free_map_q, free_map_d;
  logic [CNT_W-1:0]      in_use_q, in_use_d;
  logic [CNT_W-1:0]      peak_q, peak_d;
  logic [ADDR_W-1:0]     fail_q, fail_d;

  logic                  kind_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [IDX_W-1:0]      idx_q;

  logic                  out_valid_q, out_valid_d;
  logic [1:0]            out_status_q, out_status_d;
  logic [ADDR_W-1:0]     out_addr_q, out_addr_d;

  logic                  accept;
  logic                  finish;
  logic [SIZE_W-1:0]     size;
  logic [CNT_W-1:0]      eff;
  logic [IDX_W-1:0]      first_idx;
  logic                  u_done;
  logic [ADDR_W-1:0]     u_res;
  logic [SIZE_W-1:0]     u_rem;
  op_e                   u_op;
  logic [ADDR_W-1:0]     u_opa;
  logic                  free_ok;

  assign size   = align_size(bsize_q);
  assign eff    = eff_count(bcount_q);
  assign accept = req.valid && req.ready;
  assign finish = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

  bba_find_first u_find (
    .map_i (free_map_q),
    .idx_o (first_idx)
  );

  assign u_op  = (req.kind == KIND_FREE) ? OP_DIV : OP_MUL;
  assign u_opa = (req.kind == KIND_FREE) ? (req.address - base_q) : base_q;

  bba_serial_unit u_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .op_i     (u_op),
    .opa_i    (u_opa),
    .opb_i    (size),
    .mplier_i (first_idx),
    .done_o   (u_done),
    .res_o    (u_res),
    .rem_o    (u_rem)
  );

  // quotient below the block count is the same as offset inside the pool span
  assign free_ok = (addr_q != '0) && (size != '0) && (u_rem == '0)
                && (u_res < ADDR_W'(eff)) && !free_map_q[u_res[IDX_W-1:0]];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_RUN;
      S_RUN:  if (u_done) state_d = S_DONE;
      S_DONE: if (finish) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    free_map_d   = free_map_q;
    in_use_d     = in_use_q;
    peak_d       = peak_q;
    fail_d       = fail_q;
    out_valid_d  = out_valid_q && !rsp.ready;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    if (finish) begin
      out_valid_d = 1'b1;
      out_addr_d  = '0;
      if (kind_q == KIND_ALLOC) begin
        if (free_map_q == '0) begin
          fail_d       = fail_q + ADDR_W'(1);
          out_status_d = ST_EMPTY;
        end else begin
          free_map_d[idx_q] = 1'b0;
          in_use_d          = in_use_q + CNT_W'(1);
          if (in_use_d > peak_q) begin
            peak_d = in_use_d;
          end
          out_status_d = ST_OK;
          out_addr_d   = u_res;
        end
      end else if (free_ok) begin
        free_map_d[u_res[IDX_W-1:0]] = 1'b1;
        in_use_d     = in_use_q - CNT_W'(1);
        out_status_d = ST_OK;
      end else begin
        out_status_d = ST_INVALID;
      end
    end
    if (cfg_we_i && (cfg_index_i == CFG_BASE || cfg_index_i == CFG_BSIZE
                     || cfg_index_i == CFG_COUNT)) begin
      free_map_d = (cfg_index_i == CFG_COUNT) ? init_map(cfg_data_i[CNT_W-1:0])
                                               : init_map(bcount_q);
      in_use_d   = '0;
      peak_d     = '0;
      fail_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      base_q       <= '0;
      bsize_q      <= BSIZE_W'(4);
      bcount_q     <= CNT_W'(MAX_BLOCKS);
      free_map_q   <= '1;
      in_use_q     <= '0;
      peak_q       <= '0;
      fail_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_map_q  <= free_map_d;
      in_use_q    <= in_use_d;
      peak_q      <= peak_d;
      fail_q      <= fail_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_BASE:  base_q   <= cfg_data_i;
          CFG_BSIZE: bsize_q  <= cfg_data_i[BSIZE_W-1:0];
          CFG_COUNT: bcount_q <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= req.kind;
      addr_q <= req.address;
      idx_q  <= first_idx;
    end
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
  end

  assign req.ready         = (state_q == S_IDLE);
  assign rsp.valid         = out_valid_q;
  assign rsp.status        = out_status_q;
  assign rsp.block_address = out_addr_q;

  // counters are sampled into the response at load time
  logic [CNT_W-1:0]  out_in_use_q, out_peak_q;
  logic [ADDR_W-1:0] out_fail_q;

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_in_use_q <= in_use_d;
      out_peak_q   <= peak_d;
      out_fail_q   <= fail_d;
    end
  end

  assign rsp.in_use_count  = out_in_use_q;
  assign rsp.peak_count    = out_peak_q;
  assign rsp.failure_count = out_fail_q;

endmodule

// ===== rtl/bba_checker.sv =====
// Port-level assertions for the block pool allocator, bound to the top level.
`timescale 1ns / 1ps
module bba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [1:0]  rsp_status_i,
  input logic [31:0] rsp_addr_i,
  input logic [5:0]  rsp_in_use_i,
  input logic [5:0]  rsp_peak_i
);
  import bba_pkg::*;

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
                                    && $stable(rsp_addr_i))
    else $error("stalled response changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i == ST_OK || rsp_status_i == ST_EMPTY
                     || rsp_status_i == ST_INVALID))
    else $error("unknown status code");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_OK |-> rsp_addr_i == '0)
    else $error("address returned on a refused transaction");

  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_in_use_i <= rsp_peak_i) && (rsp_peak_i <= 6'(MAX_BLOCKS)))
    else $error("in-use count above peak or capacity");

  // one transaction at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req.valid),
  .req_ready_i  (req.ready),
  .rsp_valid_i  (rsp.valid),
  .rsp_ready_i  (rsp.ready),
  .rsp_status_i (rsp.status),
  .rsp_addr_i   (rsp.block_address),
  .rsp_in_use_i (rsp.in_use_count),
  .rsp_peak_i   (rsp.peak_count)
);
